FILE: rtl/aging_priority_scheduler_macros.svh
// ---------------------------------------------------------------------------
// Aging priority scheduler assertion macros
// Shared property shorthands for the port checker; clk and rst come from
// the scope of the use.
// ---------------------------------------------------------------------------
`ifndef AGING_PRIORITY_SCHEDULER_MACROS_SVH
`define AGING_PRIORITY_SCHEDULER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define APS_ASSERT_IMPL(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("aps implication violated");

// Next-cycle implication, checked at every edge.
`define APS_ASSERT_NEXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
    else $error("aps next-cycle implication violated");

`endif

FILE: rtl/aps_pkg.sv
// ---------------------------------------------------------------------------
// aps_pkg
// Types, codes and sizes shared by the aging priority scheduler modules.
// ---------------------------------------------------------------------------
package aps_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [1:0] ST_ACCEPTED   = 2'd0;
  localparam logic [1:0] ST_TABLE_FULL = 2'd1;
  localparam logic [1:0] ST_ZERO_BURST = 2'd2;
  localparam logic [1:0] ST_TICK_DONE  = 2'd3;

  localparam logic [1:0] REG_PRIORITY_WEIGHT  = 2'd0;
  localparam logic [1:0] REG_REMAINING_WEIGHT = 2'd1;
  localparam logic [1:0] REG_AGING_PERIOD     = 2'd2;
  localparam logic [1:0] REG_UNUSED           = 2'd3;

  localparam logic [15:0] PRIO_MIN = 16'h8000;
  localparam logic [15:0] WAIT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    K_ARRIVE,
    K_ZERO,
    K_TICK
  } kind_t;

  typedef enum logic [2:0] {
    E_IDLE,
    E_SCAN,
    E_UPDATE,
    E_DIV,
    E_FINISH
  } eng_state_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  pid;
    logic [15:0] burst;
    logic [7:0]  prio;
  } cmd_t;

  typedef struct packed {
    logic [7:0] priority_weight;
    logic [7:0] remaining_weight;
    logic [7:0] aging_period;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        ran_valid;
    logic [7:0]  ran_pid;
    logic        done_valid;
    logic [7:0]  done_pid;
    logic [15:0] done_wait;
  } res_t;

endpackage

FILE: rtl/aps_front.sv
// ---------------------------------------------------------------------------
// aps_front
// Accepts input items, classifies them and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
module aps_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              op,
  input  logic [7:0]        new_pid,
  input  logic [15:0]       new_burst,
  input  logic [7:0]        new_priority,
  output logic              cmd_valid,
  output aps_pkg::cmd_t     cmd,
  input  logic              cmd_take
);

  aps_pkg::cmd_t q [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  aps_pkg::cmd_t cls;
  logic          do_push;
  logic          do_pop;

  // Zero-burst arrivals are marked here so the back end answers them at once.
  always_comb begin
    cls.pid   = new_pid;
    cls.burst = new_burst;
    cls.prio  = new_priority;
    if (op == aps_pkg::OP_TICK) begin
      cls.kind = aps_pkg::K_TICK;
    end else if (new_burst == 16'd0) begin
      cls.kind = aps_pkg::K_ZERO;
    end else begin
      cls.kind = aps_pkg::K_ARRIVE;
    end
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

FILE: rtl/aps_back.sv
// ---------------------------------------------------------------------------
// aps_back
// Task table and sequencer: inserts tasks, scans for the best score, ages
// the other tasks with a bit-serial remainder unit, and holds the result.
// ---------------------------------------------------------------------------
module aps_back (
  input  logic           clk,
  input  logic           rst,
  input  aps_pkg::cfg_t  cfg,
  input  logic           cmd_valid,
  input  aps_pkg::cmd_t  cmd,
  output logic           cmd_take,
  output logic           out_valid,
  output aps_pkg::res_t  out_res,
  input  logic           out_pop
);

  logic [aps_pkg::SLOTS-1:0] slot_valid;
  logic [7:0]                slot_pid  [aps_pkg::SLOTS];
  logic [15:0]               slot_rem  [aps_pkg::SLOTS];
  logic [15:0]               slot_prio [aps_pkg::SLOTS];
  logic [15:0]               slot_wait [aps_pkg::SLOTS];

  aps_pkg::eng_state_t state, state_next;

  logic [aps_pkg::CNT_W-1:0] cnt;
  logic [aps_pkg::IDX_W-1:0] idx;
  logic                      cnt_end;

  logic [7:0]  rd_pid;
  logic [15:0] rd_rem;
  logic [15:0] rd_prio;
  logic [15:0] rd_wait;

  logic                      free_found;
  logic [aps_pkg::IDX_W-1:0] free_idx;

  // Scan pipeline stage: products of one slot.
  logic                      sv;
  logic signed [24:0]        s_pp;
  logic [23:0]               s_pr;
  logic [aps_pkg::IDX_W-1:0] s_idx;
  logic [7:0]                s_pid;
  logic signed [24:0]        pp;
  logic [23:0]               pr;
  logic signed [25:0]        score;

  logic                      best_found;
  logic signed [25:0]        best_score;
  logic [aps_pkg::IDX_W-1:0] best_idx;
  logic [7:0]                best_pid;

  // Remainder unit for the aging test.
  logic [15:0] div_sh;
  logic [7:0]  rmd;
  logic [3:0]  step;
  logic [8:0]  trial;
  logic [7:0]  rmd_next;

  logic [15:0] rem_dec;
  logic [15:0] wait_inc;
  aps_pkg::res_t res;
  aps_pkg::res_t idle_res;

  assign idx     = cnt[aps_pkg::IDX_W-1:0];
  assign cnt_end = (cnt == aps_pkg::CNT_W'(aps_pkg::SLOTS));
  assign rd_pid  = slot_pid[idx];
  assign rd_rem  = slot_rem[idx];
  assign rd_prio = slot_prio[idx];
  assign rd_wait = slot_wait[idx];

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int s = aps_pkg::SLOTS - 1; s >= 0; s--) begin
      if (!slot_valid[s]) begin
        free_found = 1'b1;
        free_idx   = aps_pkg::IDX_W'(s);
      end
    end
  end

  // Result of an item taken in the idle state; tick fields are filled later.
  always_comb begin
    idle_res = '0;
    if (cmd.kind == aps_pkg::K_TICK) begin
      idle_res.status = aps_pkg::ST_TICK_DONE;
    end else if (cmd.kind == aps_pkg::K_ZERO) begin
      idle_res.status = aps_pkg::ST_ZERO_BURST;
    end else if (free_found) begin
      idle_res.status = aps_pkg::ST_ACCEPTED;
    end else begin
      idle_res.status = aps_pkg::ST_TABLE_FULL;
    end
  end

  assign pp    = $signed(rd_prio) * $signed({1'b0, cfg.priority_weight});
  assign pr    = rd_rem * cfg.remaining_weight;
  assign score = {s_pp[24], s_pp} + $signed({2'b00, s_pr});

  assign trial    = {rmd, div_sh[15]};
  assign rmd_next = (trial >= {1'b0, cfg.aging_period}) ?
                    8'(trial - {1'b0, cfg.aging_period}) : trial[7:0];
  assign rem_dec  = (rd_rem != 16'd0) ? rd_rem - 16'd1 : rd_rem;
  assign wait_inc = rd_wait + 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aps_pkg::E_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_take   = 1'b0;
    unique case (state)
      aps_pkg::E_IDLE: begin
        if (cmd_valid) begin
          cmd_take   = 1'b1;
          state_next = (cmd.kind == aps_pkg::K_TICK) ? aps_pkg::E_SCAN : aps_pkg::E_FINISH;
        end
      end
      aps_pkg::E_SCAN: begin
        if (cnt_end) begin
          state_next = aps_pkg::E_UPDATE;
        end
      end
      aps_pkg::E_UPDATE: begin
        if (cnt_end) begin
          state_next = aps_pkg::E_FINISH;
        end else if (!(best_found && idx == best_idx) && slot_valid[idx] &&
                     rd_wait != aps_pkg::WAIT_MAX && cfg.aging_period != 8'd0) begin
          state_next = aps_pkg::E_DIV;
        end
      end
      aps_pkg::E_DIV: begin
        if (step == 4'd15) begin
          state_next = aps_pkg::E_UPDATE;
        end
      end
      aps_pkg::E_FINISH: begin
        if (!out_valid || out_pop) begin
          state_next = aps_pkg::E_IDLE;
        end
      end
      default: state_next = aps_pkg::E_IDLE;
    endcase
  end

  // Control registers of the table and the result buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (state == aps_pkg::E_IDLE && cmd_valid && cmd.kind == aps_pkg::K_ARRIVE &&
          free_found) begin
        slot_valid[free_idx] <= 1'b1;
      end
      if (state == aps_pkg::E_UPDATE && !cnt_end && best_found && idx == best_idx &&
          rem_dec == 16'd0) begin
        slot_valid[idx] <= 1'b0;
      end
      if (state == aps_pkg::E_FINISH && (!out_valid || out_pop)) begin
        out_valid <= 1'b1;
      end else if (out_pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == aps_pkg::E_FINISH && (!out_valid || out_pop)) begin
      out_res <= res;
    end
    unique case (state)
      aps_pkg::E_IDLE: begin
        cnt        <= '0;
        sv         <= 1'b0;
        best_found <= 1'b0;
        if (cmd_valid) begin
          res <= idle_res;
          if (cmd.kind == aps_pkg::K_ARRIVE && free_found) begin
            slot_pid[free_idx]  <= cmd.pid;
            slot_rem[free_idx]  <= cmd.burst;
            slot_prio[free_idx] <= {{8{cmd.prio[7]}}, cmd.prio};
            slot_wait[free_idx] <= 16'd0;
          end
        end
      end
      aps_pkg::E_SCAN: begin
        if (!cnt_end) begin
          sv    <= slot_valid[idx];
          s_pp  <= pp;
          s_pr  <= pr;
          s_idx <= idx;
          s_pid <= rd_pid;
          cnt   <= cnt + 1'b1;
        end else begin
          sv  <= 1'b0;
          cnt <= '0;
        end
        if (sv && (!best_found || score < best_score)) begin
          best_found <= 1'b1;
          best_score <= score;
          best_idx   <= s_idx;
          best_pid   <= s_pid;
        end
      end
      aps_pkg::E_UPDATE: begin
        res.ran_valid <= best_found;
        res.ran_pid   <= best_found ? best_pid : 8'd0;
        if (!cnt_end) begin
          if (best_found && idx == best_idx) begin
            slot_rem[idx] <= rem_dec;
            if (rem_dec == 16'd0) begin
              res.done_valid <= 1'b1;
              res.done_pid   <= rd_pid;
              res.done_wait  <= rd_wait;
            end
            cnt <= cnt + 1'b1;
          end else if (slot_valid[idx] && rd_wait != aps_pkg::WAIT_MAX) begin
            slot_wait[idx] <= wait_inc;
            div_sh         <= wait_inc;
            rmd            <= 8'd0;
            step           <= 4'd0;
            if (cfg.aging_period == 8'd0) begin
              cnt <= cnt + 1'b1;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
      end
      aps_pkg::E_DIV: begin
        rmd    <= rmd_next;
        div_sh <= {div_sh[14:0], 1'b0};
        step   <= step + 4'd1;
        if (step == 4'd15) begin
          if (rmd_next == 8'd0 && rd_prio != aps_pkg::PRIO_MIN) begin
            slot_prio[idx] <= rd_prio - 16'd1;
          end
          cnt <= cnt + 1'b1;
        end
      end
      aps_pkg::E_FINISH: begin
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/aging_priority_scheduler.sv
// ---------------------------------------------------------------------------
// Aging priority scheduler
// Task table scheduler with score-based selection and priority aging.
// ---------------------------------------------------------------------------
// Usage: each input transfer (push while full is low) carries either an arrive
// item (op 0: new_pid, new_burst, new_priority) or a scheduler tick (op 1).
// Every item yields exactly one result transfer, in order, taken with pop
// while empty is low. Arrive results report accepted, table full or zero
// burst; tick results report the task that ran and any task that finished.
// Flow: an arrive item goes from the queue straight to the result, while a
// tick runs a score scan over all slots and then a table walk, with a
// remainder pass for every ready task that ages, since the aging test runs
// through a one-bit-per-cycle remainder unit. The two-entry input queue
// keeps accepting while the sequencer works, and a finished result waits in
// its own register so the sequencer can take the next item. If the receiver
// stalls, one result waits, the sequencer holds the following one, and the
// queue fills and raises full. Reset (rst, synchronous) empties both queues
// and the task table and loads the weights 10 and 1 and an aging period of
// 5. The user must write the registers over the APB port only while the
// block is idle; the block itself does not enforce it.
// ---------------------------------------------------------------------------
module aging_priority_scheduler (
  input  logic        clk,
  input  logic        rst,
  // Input queue side
  input  logic        push,
  output logic        full,
  input  logic        op,
  input  logic [7:0]  new_pid,
  input  logic [15:0] new_burst,
  input  logic signed [7:0] new_priority,
  // Result queue side
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic        ran_valid,
  output logic [7:0]  ran_pid,
  output logic        done_valid,
  output logic [7:0]  done_pid,
  output logic [15:0] done_wait,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  aps_pkg::cfg_t cfg;
  aps_pkg::cmd_t cmd;
  aps_pkg::res_t res;
  logic          cmd_valid;
  logic          cmd_take;
  logic          res_valid;
  logic          cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // The three eight-bit registers sit at addresses 0, 4 and 8.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.priority_weight  <= 8'd10;
      cfg.remaining_weight <= 8'd1;
      cfg.aging_period     <= 8'd5;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        aps_pkg::REG_PRIORITY_WEIGHT:  cfg.priority_weight  <= pwdata[7:0];
        aps_pkg::REG_REMAINING_WEIGHT: cfg.remaining_weight <= pwdata[7:0];
        aps_pkg::REG_AGING_PERIOD:     cfg.aging_period     <= pwdata[7:0];
        aps_pkg::REG_UNUSED: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      aps_pkg::REG_PRIORITY_WEIGHT:  prdata = {24'd0, cfg.priority_weight};
      aps_pkg::REG_REMAINING_WEIGHT: prdata = {24'd0, cfg.remaining_weight};
      aps_pkg::REG_AGING_PERIOD:     prdata = {24'd0, cfg.aging_period};
      default:                       prdata = 32'd0;
    endcase
  end

  // Front end: classifies each item and queues it for the sequencer.
  aps_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .op           (op),
    .new_pid      (new_pid),
    .new_burst    (new_burst),
    .new_priority (new_priority),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take)
  );

  // Back end: owns the task table and produces one result per item.
  aps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_valid (res_valid),
    .out_res   (res),
    .out_pop   (pop)
  );

  assign empty      = !res_valid;
  assign status     = res.status;
  assign ran_valid  = res.ran_valid;
  assign ran_pid    = res.ran_pid;
  assign done_valid = res.done_valid;
  assign done_pid   = res.done_pid;
  assign done_wait  = res.done_wait;

endmodule

FILE: rtl/aps_checker.sv
// ---------------------------------------------------------------------------
// aps_checker
// Port-level checks on the result channel of the scheduler.
// ---------------------------------------------------------------------------
`include "aging_priority_scheduler_macros.svh"

module aps_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic [1:0] status,
  input logic       ran_valid,
  input logic       done_valid
);

  // A result with a finished task must also report a task that ran.
  `APS_ASSERT_IMPL(a_done_needs_ran, !empty && done_valid, ran_valid)
  // Only tick results carry a running task.
  `APS_ASSERT_IMPL(a_ran_only_on_tick, !empty && ran_valid, status == aps_pkg::ST_TICK_DONE)
  // Arrive results never report a finished task.
  `APS_ASSERT_IMPL(a_arrive_no_done, !empty && status != aps_pkg::ST_TICK_DONE, !done_valid)
  // No result is shown right after reset.
  `APS_ASSERT_NEXT(a_reset_empty, rst, empty)

endmodule

bind aging_priority_scheduler aps_checker u_aps_checker (
  .clk        (clk),
  .rst        (rst),
  .empty      (empty),
  .status     (status),
  .ran_valid  (ran_valid),
  .done_valid (done_valid)
);

FILE: test/aging_priority_scheduler_tb.sv
// ---------------------------------------------------------------------------
// Aging priority scheduler testbench
// Drives arrive and tick items through the input queue, predicts every result
// with a scoreboard that keeps its own task table, and checks each result
// transfer field by field under several weight and aging settings.
// ---------------------------------------------------------------------------
module aging_priority_scheduler_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 5000000;
  localparam int RAND_PER_PHASE = 310;

  // Scoreboard: a private copy of the task table and weights. Each accepted
  // item is turned into the result it must produce, and results are matched
  // against those expectations in order.
  class sched_scoreboard;
    bit               used[aps_pkg::SLOTS];
    byte unsigned     task_id[aps_pkg::SLOTS];
    int unsigned      remaining[aps_pkg::SLOTS];
    int               prio[aps_pkg::SLOTS];
    int unsigned      waited[aps_pkg::SLOTS];
    int unsigned      prio_weight = 10;
    int unsigned      rem_weight = 1;
    int unsigned      age_period = 5;
    aps_pkg::res_t    expected_results[$];
    int               errors = 0;

    function void set_reg(int idx, int unsigned v);
      if (idx == aps_pkg::REG_PRIORITY_WEIGHT) prio_weight = v & 8'hFF;
      else if (idx == aps_pkg::REG_REMAINING_WEIGHT) rem_weight = v & 8'hFF;
      else if (idx == aps_pkg::REG_AGING_PERIOD) age_period = v & 8'hFF;
    endfunction

    function longint score(int s);
      return longint'(prio_weight) * longint'(prio[s]) +
             longint'(rem_weight) * longint'(remaining[s]);
    endfunction

    function void note_item(logic o, logic [7:0] pid, logic [15:0] burst,
                            logic signed [7:0] pr);
      aps_pkg::res_t r;
      int free_slot;
      int best;
      longint best_score;
      r = '0;
      free_slot = -1;
      best = -1;
      best_score = 0;
      if (o == aps_pkg::OP_ARRIVE) begin
        // A zero burst wins over a full table.
        if (burst == 0) begin
          r.status = aps_pkg::ST_ZERO_BURST;
        end else begin
          for (int s = 0; s < aps_pkg::SLOTS; s++)
            if (!used[s] && free_slot < 0) free_slot = s;
          if (free_slot < 0) begin
            r.status = aps_pkg::ST_TABLE_FULL;
          end else begin
            used[free_slot] = 1;
            task_id[free_slot] = pid;
            remaining[free_slot] = 32'(burst);
            prio[free_slot] = int'(pr);
            waited[free_slot] = 0;
            r.status = aps_pkg::ST_ACCEPTED;
          end
        end
      end else begin
        r.status = aps_pkg::ST_TICK_DONE;
        for (int s = 0; s < aps_pkg::SLOTS; s++)
          if (used[s] && (best < 0 || score(s) < best_score)) begin
            best = s;
            best_score = score(s);
          end
        if (best >= 0) begin
          r.ran_valid = 1;
          r.ran_pid = task_id[best];
          if (remaining[best] > 0) remaining[best]--;
          for (int s = 0; s < aps_pkg::SLOTS; s++) begin
            if (used[s] && s != best && waited[s] < aps_pkg::WAIT_MAX) begin
              waited[s]++;
              if (age_period != 0 && waited[s] % age_period == 0 && prio[s] > -32768)
                prio[s]--;
            end
          end
          if (remaining[best] == 0) begin
            r.done_valid = 1;
            r.done_pid = task_id[best];
            r.done_wait = waited[best][15:0];
            used[best] = 0;
          end
        end
      end
      expected_results = {expected_results, r};
    endfunction

    task report(string msg);
      $display("error at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(aps_pkg::res_t got);
      aps_pkg::res_t want;
      if (expected_results.size() == 0) begin
        report("result transfer with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status)
          report($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.ran_valid !== want.ran_valid)
          report($sformatf("ran_valid %0b, expected %0b", got.ran_valid, want.ran_valid));
        if (got.ran_pid !== want.ran_pid)
          report($sformatf("ran_pid %0d, expected %0d", got.ran_pid, want.ran_pid));
        if (got.done_valid !== want.done_valid)
          report($sformatf("done_valid %0b, expected %0b", got.done_valid,
                           want.done_valid));
        if (got.done_pid !== want.done_pid)
          report($sformatf("done_pid %0d, expected %0d", got.done_pid, want.done_pid));
        if (got.done_wait !== want.done_wait)
          report($sformatf("done_wait %0d, expected %0d", got.done_wait, want.done_wait));
      end
    endtask
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               push = 0;
  logic               full;
  logic               op = 0;
  logic [7:0]         new_pid = 0;
  logic [15:0]        new_burst = 0;
  logic signed [7:0]  new_priority = 0;
  logic               empty;
  logic               pop = 0;
  logic [1:0]         status;
  logic               ran_valid;
  logic [7:0]         ran_pid;
  logic               done_valid;
  logic [7:0]         done_pid;
  logic [15:0]        done_wait;
  logic               psel = 0;
  logic               penable = 0;
  logic               pwrite = 0;
  logic [3:0]         paddr = 0;
  logic [31:0]        pwdata = 0;
  logic [31:0]        prdata;
  logic               pready;

  // While steady is set neither side inserts idle cycles.
  bit                 steady = 0;
  int                 cycles = 0;
  sched_scoreboard    sb = new();

  aging_priority_scheduler dut (.*);

  always #5 clk = ~clk;

  // Guard against a hang anywhere in the run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("aging_priority_scheduler: mismatch");
      $finish;
    end
  end

  // Receiver: a result transfer happens at an edge where pop is high and
  // empty is low. Pop is then redrawn once per cycle, so stalls land on every
  // phase of the block's work.
  always @(posedge clk) begin
    aps_pkg::res_t got;
    if (!rst && pop && !empty) begin
      got = '{status, ran_valid, ran_pid, done_valid, done_pid, done_wait};
      sb.check_result(got);
    end
    pop <= steady || ($urandom_range(99) >= 19);
  end

  // Present one item and hold it until the input transfer happens. An idle
  // gap may come first; push stays high between back-to-back items.
  task send_item(logic o, logic [7:0] pid, logic [15:0] burst, logic signed [7:0] pr);
    if (!steady && $urandom_range(99) < 19) begin
      push <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    op <= o;
    new_pid <= pid;
    new_burst <= burst;
    new_priority <= pr;
    push <= 1;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_item(o, pid, burst, pr);
  endtask

  // Setup cycle, then the access cycle; the register takes the data at the
  // edge that ends the access since pready is always high.
  task write_reg(int idx, int unsigned v);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= 4'(4 * idx);
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.set_reg(idx, v);
  endtask

  // Stop pushing and wait until every expected result has been taken.
  task drain;
    push <= 0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task random_item;
    int k;
    logic [15:0] burst;
    if ($urandom_range(99) < 45) begin
      // Mostly short bursts so tasks finish and the table keeps turning over.
      k = $urandom_range(99);
      if (k < 4) burst = 16'd0;
      else if (k < 80) burst = 16'($urandom_range(1, 6));
      else if (k < 97) burst = 16'($urandom_range(7, 64));
      else burst = 16'($urandom_range(65, 400));
      send_item(aps_pkg::OP_ARRIVE, 8'($urandom), burst, 8'($urandom));
    end else begin
      send_item(aps_pkg::OP_TICK, 8'($urandom), 16'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int unsigned pw[6] = '{0, 255, 255, 0, 7, 0};
    int unsigned rw[6] = '{0, 255, 0, 255, 3, 0};
    int unsigned ap[6] = '{1, 255, 1, 3, 0, 0};

    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed items under the reset weights. An idle tick on an empty
    // table, a rejected zero burst, then tasks at the field extremes.
    send_item(aps_pkg::OP_TICK, 8'd0, 16'd0, 8'sd0);
    send_item(aps_pkg::OP_ARRIVE, 8'd9, 16'd0, 8'sd127);
    send_item(aps_pkg::OP_ARRIVE, 8'd255, 16'hFFFF, -8'sd128);
    send_item(aps_pkg::OP_ARRIVE, 8'd0, 16'd1, 8'sd127);
    send_item(aps_pkg::OP_TICK, 8'd0, 16'd0, 8'sd0);
    // Duplicate ids fill the table; then a full-table reject and a zero
    // burst on a full table, which reports the zero burst.
    for (int i = 0; i < 15; i++)
      send_item(aps_pkg::OP_ARRIVE, 8'd7, 16'(2 + i % 3), 8'(i - 4));
    send_item(aps_pkg::OP_ARRIVE, 8'd1, 16'd5, 8'sd0);
    send_item(aps_pkg::OP_ARRIVE, 8'd2, 16'd0, 8'sd0);
    repeat (4) send_item(aps_pkg::OP_TICK, 8'hFF, 16'hFFFF, -8'sd1);
    drain();

    // Write every register, including the unused index, then run random
    // items under each setting; one phase runs with no idle cycles at all.
    write_reg(aps_pkg::REG_UNUSED, 32'h55);
    for (int p = 0; p < 7; p++) begin
      if (p < 6) begin
        write_reg(aps_pkg::REG_PRIORITY_WEIGHT, pw[p]);
        write_reg(aps_pkg::REG_REMAINING_WEIGHT, rw[p]);
        write_reg(aps_pkg::REG_AGING_PERIOD, (p == 5) ? $urandom_range(1, 255) : ap[p]);
        if (p == 5) begin
          write_reg(aps_pkg::REG_PRIORITY_WEIGHT, $urandom_range(255));
          write_reg(aps_pkg::REG_REMAINING_WEIGHT, $urandom_range(255));
        end
      end else begin
        write_reg(aps_pkg::REG_PRIORITY_WEIGHT, 10);
        write_reg(aps_pkg::REG_REMAINING_WEIGHT, 1);
        write_reg(aps_pkg::REG_AGING_PERIOD, 5);
      end
      steady = (p == 2);
      for (int i = 0; i < RAND_PER_PHASE * 6 / 7; i++) random_item();
      drain();
    end
    steady = 0;

    push <= 0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0) begin
      $display("aging_priority_scheduler: match");
    end else begin
      $display("aging_priority_scheduler: mismatch");
    end
    $finish;
  end

endmodule
